// ----- hw/rtl/eapol_frame_detector_dedupe_unit_assert.svh -----
// ----------------------------------------------------------------------------
// eapol frame detector assertion macros
// shared assertion forms for the detector checker
// ----------------------------------------------------------------------------
`ifndef EAPOL_FRAME_DETECTOR_DEDUPE_UNIT_ASSERT_SVH
`define EAPOL_FRAME_DETECTOR_DEDUPE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define EFDD_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define EFDD_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/efdd_pkg.sv -----
// ----------------------------------------------------------------------------
// efdd_pkg
// types and constants of the eapol frame detector with bssid dedupe
// ----------------------------------------------------------------------------
`default_nettype none

package efdd_pkg;

  localparam int TableEntriesDefault = 24;

  localparam int PosW     = 12;
  localparam int BssidW   = 48;
  localparam int CountW   = 16;
  localparam int VerdictW = 3;

  localparam logic [PosW-1:0]   POS_MAX     = 12'd4095;
  localparam logic [PosW-1:0]   MIN_LAST    = 12'd35;  // length 36 ends at byte 35
  localparam logic [PosW-1:0]   BSSID_FIRST = 12'd16;
  localparam logic [PosW-1:0]   BSSID_LAST  = 12'd21;
  localparam logic [PosW-1:0]   HDR_PLAIN   = 12'd24;
  localparam logic [PosW-1:0]   HDR_QOS     = 12'd26;
  localparam logic [PosW-1:0]   BODY_MIN    = 12'd11;  // header + 12 bytes, minus one

  localparam logic [7:0] FC_TYPE_MASK    = 8'h0C;
  localparam logic [7:0] FC_TYPE_DATA    = 8'h08;
  localparam logic [7:0] FC_SUBTYPE_MASK = 8'hF0;
  localparam logic [7:0] FC_SUBTYPE_QOS  = 8'h80;
  localparam logic [7:0] SNAP_DSAP       = 8'hAA;
  localparam logic [7:0] SNAP_CTRL       = 8'h03;
  localparam logic [7:0] ETYPE_HI        = 8'h88;
  localparam logic [7:0] ETYPE_LO        = 8'h8E;

  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_IGNORED   = 3'd0,
    VERDICT_NOT_DATA  = 3'd1,
    VERDICT_TOO_SHORT = 3'd2,
    VERDICT_NO_SNAP   = 3'd3,
    VERDICT_NOT_EAPOL = 3'd4,
    VERDICT_EAPOL     = 3'd5
  } verdict_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              token;
    logic              hit;
    logic [BssidW-1:0] key;
  } link_t;

endpackage

`default_nettype wire

// ----- hw/rtl/efdd_cell.sv -----
// ----------------------------------------------------------------------------
// efdd_cell
// one seen-table entry; compares the passing key and hands it on
// ----------------------------------------------------------------------------
`default_nettype none

module efdd_cell #(
  parameter int Index = 0,
  parameter int FillW = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire efdd_pkg::link_t            link_in,
  output efdd_pkg::link_t                 link_out,
  input  wire logic [FillW-1:0]           fill,
  input  wire logic                       wr_en,
  input  wire logic [efdd_pkg::BssidW-1:0] wr_key
);

  logic [efdd_pkg::BssidW-1:0] entry;
  logic                        in_use;

  // entries below the fill count hold a stored bssid
  assign in_use = FillW'(Index) < fill;

  // entry store, written at the slot the fill count points to
  always_ff @(posedge clk) begin
    if (wr_en && fill == FillW'(Index)) begin
      entry <= wr_key;
    end
  end

  // compare and pass the token along
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.token <= 1'b0;
    end else begin
      link_out.token <= link_in.token;
    end
    link_out.key <= link_in.key;
    link_out.hit <= link_in.hit | (in_use && entry == link_in.key);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/efdd_parser.sv -----
// ----------------------------------------------------------------------------
// efdd_parser
// walks the frame bytes, captures header fields and forms the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module efdd_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [7:0]                  byte_value,
  input  wire logic                        last_byte,
  input  wire logic                        capture_enable,
  output efdd_pkg::verdict_t               verdict,
  output logic [efdd_pkg::BssidW-1:0]      bssid
);

  logic [efdd_pkg::PosW-1:0] pos;
  logic [7:0]                fc;
  logic [4:0]                flags;
  logic [efdd_pkg::PosW-1:0] hdr;
  logic [4:0]                flags_set;

  // header length follows the qos subtype
  assign hdr = ((fc & efdd_pkg::FC_SUBTYPE_MASK) == efdd_pkg::FC_SUBTYPE_QOS) ?
               efdd_pkg::HDR_QOS : efdd_pkg::HDR_PLAIN;

  // llc/snap and ethertype byte matches
  always_comb begin
    flags_set    = 5'd0;
    flags_set[0] = (pos == hdr) && (byte_value == efdd_pkg::SNAP_DSAP);
    flags_set[1] = (pos == hdr + 12'd1) && (byte_value == efdd_pkg::SNAP_DSAP);
    flags_set[2] = (pos == hdr + 12'd2) && (byte_value == efdd_pkg::SNAP_CTRL);
    flags_set[3] = (pos == hdr + 12'd6) && (byte_value == efdd_pkg::ETYPE_HI);
    flags_set[4] = (pos == hdr + 12'd7) && (byte_value == efdd_pkg::ETYPE_LO);
  end

  // frame state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      fc    <= '0;
      flags <= '0;
      bssid <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos   <= '0;
        fc    <= '0;
        flags <= '0;
        bssid <= '0;
      end else begin
        if (pos == '0) begin
          fc <= byte_value;
        end
        if (pos >= efdd_pkg::BSSID_FIRST && pos <= efdd_pkg::BSSID_LAST) begin
          bssid <= {bssid[efdd_pkg::BssidW-9:0], byte_value};
        end
        flags <= flags | flags_set;
        if (pos < efdd_pkg::POS_MAX) begin
          pos <= pos + 12'd1;
        end
      end
    end
  end

  // verdict on the last byte; every field it needs is complete by byte 35
  always_comb begin
    if (!capture_enable || pos < efdd_pkg::MIN_LAST) begin
      verdict = efdd_pkg::VERDICT_IGNORED;
    end else if ((fc & efdd_pkg::FC_TYPE_MASK) != efdd_pkg::FC_TYPE_DATA) begin
      verdict = efdd_pkg::VERDICT_NOT_DATA;
    end else if (pos < hdr + efdd_pkg::BODY_MIN) begin
      verdict = efdd_pkg::VERDICT_TOO_SHORT;
    end else if (flags[2:0] != 3'b111) begin
      verdict = efdd_pkg::VERDICT_NO_SNAP;
    end else if (flags[4:3] != 2'b11) begin
      verdict = efdd_pkg::VERDICT_NOT_EAPOL;
    end else begin
      verdict = efdd_pkg::VERDICT_EAPOL;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/eapol_frame_detector_dedupe_unit.sv -----
// ----------------------------------------------------------------------------
// eapol_frame_detector_dedupe_unit
// classifies 802.11 frames and counts distinct access points of eapol frames
// ----------------------------------------------------------------------------
// result: registered in the cycle after the last byte; for an eapol frame it
//   follows the start register and the bssid walking the chain of table cells
// throughput: one byte per cycle; input stalls during the table walk and on a last byte while the result is held
// reset: synchronous, clears frame state, fill count, access point count and
//   capture_enable; table entries are only read below the fill count
`default_nettype none

module eapol_frame_detector_dedupe_unit #(
  parameter int TABLE_ENTRIES = efdd_pkg::TableEntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte_value [7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // verdict [2:0], new_access_point [3], access_point_count [19:4],
  // table_full [20], zero pad [23:21]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  // capture_enable
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  localparam int FillW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t                         state;
  logic                           capture_enable;
  logic                           in_accept;
  efdd_pkg::verdict_t             verdict;
  logic [efdd_pkg::BssidW-1:0]    bssid;
  logic [efdd_pkg::BssidW-1:0]    key;
  logic                           start;
  logic [FillW-1:0]               fill;
  logic [efdd_pkg::CountW-1:0]    count;
  logic [efdd_pkg::CountW-1:0]    count_next;
  logic                           full;
  logic                           wr_en;
  efdd_pkg::link_t                links [TABLE_ENTRIES+1];
  efdd_pkg::link_t                tail;

  logic                           out_valid;
  efdd_pkg::verdict_t             out_verdict;
  logic                           out_new;
  logic [efdd_pkg::CountW-1:0]    out_count;
  logic                           out_full;

  // handshakes; a non-last byte never needs the result slot
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) &&
                         (!out_valid || m_axis_tready || !s_axis_tlast);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      capture_enable <= cfg_data;
    end
  end

  // byte parser
  efdd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .byte_value    (s_axis_tdata),
    .last_byte     (s_axis_tlast),
    .capture_enable(capture_enable),
    .verdict       (verdict),
    .bssid         (bssid)
  );

  // chain of table cells
  assign links[0] = '{token: start, hit: 1'b0, key: key};
  assign tail     = links[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    efdd_cell #(
      .Index(i),
      .FillW(FillW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .link_in (links[i]),
      .link_out(links[i+1]),
      .fill    (fill),
      .wr_en   (wr_en),
      .wr_key  (key)
    );
  end

  assign full       = fill == FillW'(TABLE_ENTRIES);
  assign wr_en      = tail.token && !tail.hit && !full;
  assign count_next = (count < efdd_pkg::COUNT_MAX) ? count + 16'd1 : count;

  // sequencer, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      fill      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && s_axis_tlast) begin
            if (verdict == efdd_pkg::VERDICT_EAPOL) begin
              key   <= bssid;
              start <= 1'b1;
              state <= ST_SEARCH;
            end else begin
              out_valid   <= 1'b1;
              out_verdict <= verdict;
              out_new     <= 1'b0;
              out_count   <= count;
              out_full    <= full;
            end
          end
        end
        ST_SEARCH: begin
          if (tail.token) begin
            out_valid   <= 1'b1;
            out_verdict <= efdd_pkg::VERDICT_EAPOL;
            out_new     <= !tail.hit;
            if (tail.hit) begin
              out_count <= count;
              out_full  <= full;
            end else begin
              count     <= count_next;
              out_count <= count_next;
              if (!full) begin
                fill     <= fill + FillW'(1);
                out_full <= (fill + FillW'(1)) == FillW'(TABLE_ENTRIES);
              end else begin
                out_full <= 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_full, out_count, out_new, out_verdict};

endmodule

`default_nettype wire

// ----- hw/rtl/efdd_checker.sv -----
// ----------------------------------------------------------------------------
// efdd_checker
// port-level checks on the eapol frame detector results
// ----------------------------------------------------------------------------
`default_nettype none

`include "eapol_frame_detector_dedupe_unit_assert.svh"

module efdd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  logic        saw_full;
  logic [15:0] last_count;
  logic        out_done;

  assign out_done = m_axis_tvalid && m_axis_tready;

  // history of delivered results
  always_ff @(posedge clk) begin
    if (rst) begin
      saw_full   <= 1'b0;
      last_count <= '0;
    end else if (out_done) begin
      saw_full   <= saw_full | m_axis_tdata[20];
      last_count <= m_axis_tdata[19:4];
    end
  end

  `EFDD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `EFDD_ASSERT_NOW(a_new_only_eapol, clk, rst, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == 3'd5, "new access point flagged on non-eapol verdict")
  `EFDD_ASSERT_NOW(a_count_monotonic, clk, rst, m_axis_tvalid, m_axis_tdata[19:4] >= last_count, "access point count went down")
  `EFDD_ASSERT_NOW(a_full_sticks, clk, rst, m_axis_tvalid && saw_full, m_axis_tdata[20], "table full flag dropped")

endmodule

bind eapol_frame_detector_dedupe_unit efdd_checker u_efdd_checker (.*);

`default_nettype wire
